// ===== sv/pdq_pkg.sv =====
// Shared types and codes for the process record deque.
// No dependencies; imported by the core and its checker.
package pdq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int KIND_W   = 3;
    localparam int PID_W    = 16;
    localparam int TIME_W   = 24;
    localparam int REC_W    = PID_W + 2 * TIME_W;
    localparam int STATUS_W = 2;
    localparam int M_USER_W = 1 + STATUS_W;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SORT_JOB   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ORDER_PID  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] job;
    } rec_t;

endpackage

// ===== sv/process_deque_with_sort_core.sv =====
// Bounded deque of process records in a ring RAM, with in-place insertion sorts.
// Depends on pdq_pkg and pdq_ram.
// A sort inserts each entry after the front into place using one RAM read port and one
// shared compare. One request at a time.
// Reset (aresetn low, synchronous) empties the queue; RAM contents are not cleared.
module process_deque_with_sort_core #(
    parameter  int QUEUE_DEPTH = pdq_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W    = $clog2(QUEUE_DEPTH),
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1),
    localparam int M_DATA_W = ((pdq_pkg::REC_W + CNT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pdq_pkg::KIND_W-1:0]    s_tuser,  // kind
    input  logic [pdq_pkg::REC_W-1:0]     s_tdata,  // entry_pid, entry_arrival, entry_job_time
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pdq_pkg::M_USER_W-1:0]  m_tuser,  // out_valid, status
    output logic [M_DATA_W-1:0]           m_tdata   // out_pid, out_arrival, out_job_time,
                                                    // occupancy, zero pad
);
    import pdq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_NEXT   = 4'd3;
    localparam logic [3:0] S_LDCUR  = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_RD     = 4'd6;
    localparam logic [3:0] S_PUT    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg;
    rec_t                rec_in_reg;
    logic [PTR_W-1:0]    front_reg, back_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    i_reg, k_reg, addr_i_reg, addr_k_reg;
    rec_t                cur_reg;
    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    rec_t                res_rec_reg;
    logic                m_tvalid_reg;
    logic [M_USER_W-1:0] m_tuser_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                ram_we, ram_re;
    logic [PTR_W-1:0]    ram_waddr, ram_raddr;
    rec_t                ram_wdata, ram_rdata;

    logic full, empty, move, out_free, last_i, is_sort, is_push, is_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_i   = (CNT_W'(i_reg) + CNT_W'(1)) == count_reg;
    assign is_push  = (kind_reg == KIND_PUSH_FRONT) || (kind_reg == KIND_PUSH_BACK);
    assign is_pop   = (kind_reg == KIND_POP_FRONT) || (kind_reg == KIND_POP_BACK);
    assign is_sort  = (kind_reg == KIND_SORT_JOB) || (kind_reg == KIND_ORDER_PID);

    // shared compare: ram_rdata holds the entry before slot k
    always_comb begin
        if (kind_reg == KIND_ORDER_PID) begin
            move = (ram_rdata.arrival == cur_reg.arrival) && (ram_rdata.pid > cur_reg.pid);
        end else begin
            move = cur_reg.job < ram_rdata.job;
        end
    end

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_k_reg;
        ram_wdata  = cur_reg;
        ram_re     = 1'b0;
        ram_raddr  = addr_i_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                unique case (kind_reg) inside
                    KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                        if (!full) begin
                            ram_we    = 1'b1;
                            ram_waddr = (kind_reg == KIND_PUSH_FRONT) ? ring_prev(front_reg)
                                                                      : back_reg;
                            ram_wdata = rec_in_reg;
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_BACK: begin
                        if (!empty) begin
                            ram_re     = 1'b1;
                            ram_raddr  = (kind_reg == KIND_POP_FRONT) ? front_reg
                                                                      : ring_prev(back_reg);
                            state_next = S_RDWAIT;
                        end
                    end
                    KIND_SORT_JOB, KIND_ORDER_PID: begin
                        if (count_reg >= CNT_W'(2)) begin
                            state_next = S_NEXT;
                        end
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_RDWAIT: begin
                state_next = S_FIN;
            end
            S_NEXT: begin
                ram_re     = 1'b1;
                ram_raddr  = addr_i_reg;
                state_next = S_LDCUR;
            end
            S_LDCUR: begin
                ram_re     = 1'b1;
                ram_raddr  = ring_prev(addr_i_reg);
                state_next = S_CMP;
            end
            S_CMP: begin
                if (move) begin
                    ram_we     = 1'b1;
                    ram_waddr  = addr_k_reg;
                    ram_wdata  = ram_rdata;
                    state_next = (k_reg == PTR_W'(1)) ? S_PUT : S_RD;
                end else begin
                    state_next = S_PUT;
                end
            end
            S_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = ring_prev(addr_k_reg);
                state_next = S_CMP;
            end
            S_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = addr_k_reg;
                ram_wdata  = cur_reg;
                state_next = last_i ? S_FIN : S_NEXT;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            back_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EXEC) begin
                if (is_push && !full) begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (kind_reg == KIND_PUSH_FRONT) begin
                        front_reg <= ring_prev(front_reg);
                    end else begin
                        back_reg <= ring_next(back_reg);
                    end
                end
                if (is_pop && !empty) begin
                    count_reg <= count_reg - CNT_W'(1);
                    if (kind_reg == KIND_POP_FRONT) begin
                        front_reg <= ring_next(front_reg);
                    end else begin
                        back_reg <= ring_prev(back_reg);
                    end
                end
            end
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and sort walk
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_reg           <= s_tuser;
                    rec_in_reg.pid     <= s_tdata[PID_W-1:0];
                    rec_in_reg.arrival <= s_tdata[PID_W +: TIME_W];
                    rec_in_reg.job     <= s_tdata[PID_W+TIME_W +: TIME_W];
                    res_valid_reg      <= 1'b0;
                    res_status_reg     <= ST_OK;
                    res_rec_reg        <= '0;
                end
            end
            S_EXEC: begin
                if (is_push && full) begin
                    res_status_reg <= ST_FULL;
                end
                if (is_pop) begin
                    if (empty) begin
                        res_status_reg <= ST_EMPTY;
                    end else begin
                        res_valid_reg <= 1'b1;
                    end
                end
                if (is_sort) begin
                    i_reg      <= PTR_W'(1);
                    addr_i_reg <= ring_next(front_reg);
                end
            end
            S_RDWAIT: begin
                res_rec_reg <= ram_rdata;
            end
            S_LDCUR: begin
                cur_reg    <= ram_rdata;
                k_reg      <= i_reg;
                addr_k_reg <= addr_i_reg;
            end
            S_CMP: begin
                if (move) begin
                    k_reg      <= k_reg - PTR_W'(1);
                    addr_k_reg <= ring_prev(addr_k_reg);
                end
            end
            S_PUT: begin
                i_reg      <= i_reg + PTR_W'(1);
                addr_i_reg <= ring_next(addr_i_reg);
            end
            S_FIN: begin
                if (out_free) begin
                    m_tuser_reg <= {res_status_reg, res_valid_reg};
                    m_tdata_reg <= M_DATA_W'({count_reg, res_rec_reg.job,
                                              res_rec_reg.arrival, res_rec_reg.pid});
                end
            end
            default: begin
            end
        endcase
    end

    pdq_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/pdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pdq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/pdq_checker.sv =====
// Port-level checks for the process record deque, bound to the core.
// Depends on pdq_pkg and process_deque_with_sort_core.
module pdq_checker #(
    parameter  int QUEUE_DEPTH = pdq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1),
    localparam int M_DATA_W = ((pdq_pkg::REC_W + CNT_W + 7) / 8) * 8
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pdq_pkg::M_USER_W-1:0]  m_tuser,
    input logic [M_DATA_W-1:0]           m_tdata
);
    import pdq_pkg::*;

    logic [CNT_W-1:0] occ;
    assign occ = m_tdata[REC_W +: CNT_W];

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // busy after a request is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");

    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[STATUS_W:1] == ST_OK && occ < CNT_W'(QUEUE_DEPTH))
        else $error("returned entry with bad status or occupancy");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[REC_W-1:0] == '0)
        else $error("entry fields not zero without a returned entry");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> occ <= CNT_W'(QUEUE_DEPTH) &&
                     (m_tuser[STATUS_W:1] == ST_OK || m_tuser[STATUS_W:1] == ST_EMPTY ||
                      m_tuser[STATUS_W:1] == ST_FULL))
        else $error("status or occupancy out of range");

endmodule

bind process_deque_with_sort_core pdq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pdq_checker (.*);
